// File: rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/i2cmbw_pkg.sv
// shared types and constants of the i2c byte writer
package i2cmbw_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_BYTE  = 2'd2,
        CMD_STOP  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
        logic       sda;
    } t_req;

    typedef struct packed {
        logic scl;
        logic sda;
        logic busy;
        logic ack_valid;
        logic no_ack;
        logic rejected;
    } t_res;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] TICKS_RESET   = 8'd2;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [1:0] LAST_PHASE    = 2'd2;

endpackage

// File: rtl/i2c_master_byte_writer.sv
// top level of the write-only i2c master: request queue in front of the bus sequencer
// a request is taken every cycle while the two-entry queue has room
// its result passes the queue and the result register before it shows on o_valid
// the sequencer handles one per clock, a sustained rate of one request per cycle while the result side does not stall
// synchronous active-low reset empties the queue, idles the bus with scl and sda released,
// sets the no-ack level to one and the ticks per delay unit to two
module i2c_master_byte_writer
    import i2cmbw_pkg::*;
#(
    parameter int DELAY_COUNT_WIDTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_data_byte,
    input  logic       i_sda_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_scl_out,
    output logic       o_sda_out,
    output logic       o_busy_res,
    output logic       o_ack_valid,
    output logic       o_no_ack,
    output logic       o_cmd_rejected
);

    logic q_valid;
    t_req q_req;
    logic pop;
    t_res res;

    i2cmbw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .i_sda_in    (i_sda_in),
        .o_q_valid   (q_valid),
        .o_q_req     (q_req),
        .i_pop       (pop)
    );

    i2cmbw_back #(
        .DELAY_COUNT_WIDTH (DELAY_COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_req     (q_req),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (res)
    );

    assign o_scl_out      = res.scl;
    assign o_sda_out      = res.sda;
    assign o_busy_res     = res.busy;
    assign o_ack_valid    = res.ack_valid;
    assign o_no_ack       = res.no_ack;
    assign o_cmd_rejected = res.rejected;

endmodule

// File: rtl/i2cmbw_front.sv
// front end: classifies incoming requests and queues them for the sequencer
`include "assert_macros.svh"
module i2cmbw_front
    import i2cmbw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_data_byte,
    input  logic       i_sda_in,
    output logic       o_q_valid,
    output t_req       o_q_req,
    input  logic       i_pop
);

    t_req              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    t_req              req_in;

    assign o_stall   = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_count != '0);
    assign o_q_req   = r_mem[r_rd_ptr];

    always_comb begin
        req_in.cmd  = t_cmd'(i_kind);
        req_in.sda  = i_sda_in;
        // only start and byte requests carry a byte
        req_in.data = (req_in.cmd == CMD_START || req_in.cmd == CMD_BYTE) ? i_data_byte : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= req_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_IMPLIES(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= QCNT_W'(QUEUE_DEPTH))
    `ASSERT_IMPLIES(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != '0)
    `ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

// File: rtl/i2cmbw_back.sv
// back end: bus sequencer that executes queued requests and holds the result register
`include "assert_macros.svh"
module i2cmbw_back
    import i2cmbw_pkg::*;
#(
    parameter int DELAY_COUNT_WIDTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_q_valid,
    input  t_req       i_q_req,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output t_res       o_res
);

    localparam int W  = DELAY_COUNT_WIDTH;
    localparam int TW = (W > 8) ? W : 8;

    typedef enum logic [2:0] {
        SEQ_IDLE  = 3'd0,
        SEQ_START = 3'd1,
        SEQ_BIT   = 3'd2,
        SEQ_ACK   = 3'd3,
        SEQ_STOP  = 3'd4
    } t_seq;

    t_seq         r_seq,   n_seq;
    logic [1:0]   r_phase, n_phase;
    logic [3:0]   r_bit,   n_bit;
    logic [7:0]   r_shift, n_shift;
    logic [W-1:0] r_tick,  n_tick;
    logic         r_scl,   n_scl;
    logic         r_sda,   n_sda;
    logic         r_ack,   n_ack;
    logic [W-1:0] r_target;
    logic         r_out_valid;
    t_res         r_out;
    logic         busy;
    logic         sampled;
    logic         rejected;
    logic         do_enter;
    logic [TW-1:0] cfg_ext;
    logic [TW-1:0] cfg_clamp;
    logic [W-1:0]  cfg_target;

    // zero acts as one, oversize clamps to the largest count
    always_comb begin
        cfg_ext = TW'(i_cfg_wdata);
        if (cfg_ext == '0) begin
            cfg_clamp = TW'(1);
        end else if (cfg_ext > TW'({W{1'b1}})) begin
            cfg_clamp = TW'({W{1'b1}});
        end else begin
            cfg_clamp = cfg_ext;
        end
        cfg_target = cfg_clamp[W-1:0];
    end

    assign o_pop   = i_q_valid && (!r_out_valid || !i_stall);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign busy    = (r_seq != SEQ_IDLE);

    always_comb begin
        n_seq    = r_seq;
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_tick   = r_tick;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_ack    = r_ack;
        sampled  = 1'b0;
        rejected = 1'b0;
        do_enter = 1'b0;

        if (i_q_req.cmd == CMD_TICK) begin
            if (busy) begin
                n_tick = r_tick + 1'b1;
                if (n_tick >= r_target) begin
                    if (r_phase < LAST_PHASE) begin
                        n_phase  = r_phase + 2'd1;
                        do_enter = 1'b1;
                        // ack sampled at the end of the scl high step
                        if (r_seq == SEQ_ACK && n_phase == LAST_PHASE) begin
                            n_ack   = i_q_req.sda;
                            sampled = 1'b1;
                        end
                    end else begin
                        n_phase = 2'd0;
                        case (r_seq)
                            SEQ_START: begin
                                n_seq    = SEQ_BIT;
                                n_bit    = 4'd0;
                                do_enter = 1'b1;
                            end
                            SEQ_BIT: begin
                                n_shift  = {r_shift[6:0], 1'b0};
                                n_bit    = r_bit + 4'd1;
                                if (n_bit >= BITS_PER_BYTE) begin
                                    n_seq = SEQ_ACK;
                                    n_bit = 4'd0;
                                end
                                do_enter = 1'b1;
                            end
                            default: begin
                                n_seq  = SEQ_IDLE;
                                n_tick = '0;
                            end
                        endcase
                    end
                end
            end
        end else if (busy) begin
            rejected = 1'b1;
        end else begin
            n_phase  = 2'd0;
            n_bit    = 4'd0;
            do_enter = 1'b1;
            case (i_q_req.cmd)
                CMD_START: begin
                    n_shift = i_q_req.data;
                    n_seq   = SEQ_START;
                end
                CMD_BYTE: begin
                    n_shift = i_q_req.data;
                    n_seq   = SEQ_BIT;
                end
                default: begin
                    n_seq = SEQ_STOP;
                end
            endcase
        end

        if (do_enter) begin
            n_tick = '0;
            case (n_seq)
                SEQ_START: begin
                    if (n_phase == 2'd0) begin
                        n_sda = 1'b1;
                        n_scl = 1'b1;
                    end else if (n_phase == 2'd1) begin
                        n_sda = 1'b0;
                    end else begin
                        n_scl = 1'b0;
                    end
                end
                SEQ_BIT: begin
                    if (n_phase == 2'd0) begin
                        n_sda = n_shift[7];
                    end else begin
                        n_scl = (n_phase == 2'd1);
                    end
                end
                SEQ_ACK: begin
                    if (n_phase == 2'd0) begin
                        n_sda = 1'b1;
                    end else begin
                        n_scl = (n_phase == 2'd1);
                    end
                end
                SEQ_STOP: begin
                    if (n_phase == 2'd0) begin
                        n_sda = 1'b0;
                    end else if (n_phase == 2'd1) begin
                        n_scl = 1'b1;
                    end else begin
                        n_sda = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SEQ_IDLE;
            r_phase     <= 2'd0;
            r_bit       <= 4'd0;
            r_shift     <= 8'd0;
            r_tick      <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_ack       <= 1'b1;
            r_target    <= W'(TICKS_RESET);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_target <= cfg_target;
            end
            if (o_pop) begin
                r_seq           <= n_seq;
                r_phase         <= n_phase;
                r_bit           <= n_bit;
                r_shift         <= n_shift;
                r_tick          <= n_tick;
                r_scl           <= n_scl;
                r_sda           <= n_sda;
                r_ack           <= n_ack;
                r_out_valid     <= 1'b1;
                r_out.scl       <= n_scl;
                r_out.sda       <= n_sda;
                r_out.busy      <= (n_seq != SEQ_IDLE);
                r_out.ack_valid <= sampled;
                r_out.no_ack    <= n_ack;
                r_out.rejected  <= rejected;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `ASSERT_IMPLIES(a_sample_in_ack, i_clk, i_rst_n, o_pop && sampled, r_seq == SEQ_ACK)
    `ASSERT_NEXT(a_reject_holds, i_clk, i_rst_n, o_pop && rejected, r_seq == $past(r_seq))
    `ASSERT_IMPLIES(a_busy_matches, i_clk, i_rst_n, r_out_valid, r_out.busy == (r_seq != SEQ_IDLE))
    `ASSERT_NEXT(a_pop_loads, i_clk, i_rst_n, o_pop, r_out_valid)

endmodule

// File: dv/tb.sv
// testbench for the write-only i2c byte writer: queued random commands checked against a line-level model
module tb
    import i2cmbw_pkg::*;
();

    localparam int TICK_W      = 8;
    localparam int TICK_MAX    = (1 << TICK_W) - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [2:0] {
        BUS_IDLE,
        BUS_START,
        BUS_BIT,
        BUS_ACK,
        BUS_STOP
    } t_bus_seq;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_PERIODIC,
        RX_RARE
    } t_rx_mode;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = 8'd0;
    logic       i_valid     = 1'b0;
    logic [1:0] i_kind      = CMD_TICK;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_sda_in    = 1'b1;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_scl_out;
    logic       o_sda_out;
    logic       o_busy_res;
    logic       o_ack_valid;
    logic       o_no_ack;
    logic       o_cmd_rejected;

    i2c_master_byte_writer #(
        .DELAY_COUNT_WIDTH(TICK_W)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_data_byte   (i_data_byte),
        .i_sda_in      (i_sda_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_scl_out     (o_scl_out),
        .o_sda_out     (o_sda_out),
        .o_busy_res    (o_busy_res),
        .o_ack_valid   (o_ack_valid),
        .o_no_ack      (o_no_ack),
        .o_cmd_rejected(o_cmd_rejected)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // line model state
    t_bus_seq          m_seq;
    logic [1:0]        m_phase;
    logic [3:0]        m_bit;
    logic [7:0]        m_shift;
    logic [TICK_W-1:0] m_ticks;
    logic [7:0]        m_tpd;
    logic              m_scl;
    logic              m_sda;
    logic              m_ack;

    t_req   cmd_q[$];
    t_res   line_exp_q[$];
    int     cmds_queued   = 0;
    int     cmds_taken    = 0;
    int     lines_seen    = 0;
    int     mismatch_cnt  = 0;
    int     cycle_cnt     = 0;
    logic   req_taken     = 1'b0;

    task automatic reset_line_model();
        m_seq   = BUS_IDLE;
        m_phase = '0;
        m_bit   = '0;
        m_shift = '0;
        m_ticks = '0;
        m_tpd   = TICKS_RESET;
        m_scl   = 1'b1;
        m_sda   = 1'b1;
        m_ack   = 1'b1;
    endtask

    function automatic void enter_step();
        m_ticks = '0;
        case (m_seq)
            BUS_START: begin
                if (m_phase == 2'd0) begin
                    m_sda = 1'b1;
                    m_scl = 1'b1;
                end else if (m_phase == 2'd1) m_sda = 1'b0;
                else m_scl = 1'b0;
            end
            BUS_BIT: begin
                if (m_phase == 2'd0) m_sda = m_shift[7];
                else if (m_phase == 2'd1) m_scl = 1'b1;
                else m_scl = 1'b0;
            end
            BUS_ACK: begin
                if (m_phase == 2'd0) m_sda = 1'b1;
                else if (m_phase == 2'd1) m_scl = 1'b1;
                else m_scl = 1'b0;
            end
            BUS_STOP: begin
                if (m_phase == 2'd0) m_sda = 1'b0;
                else if (m_phase == 2'd1) m_scl = 1'b1;
                else m_sda = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // end of a delay unit, returns 1 when the ack level was captured
    function automatic logic end_delay_unit(logic pin);
        logic sampled;
        sampled = 1'b0;
        if (m_phase < LAST_PHASE) begin
            m_phase = m_phase + 2'd1;
            if (m_seq == BUS_ACK && m_phase == LAST_PHASE) begin
                m_ack   = pin;
                sampled = 1'b1;
            end
            enter_step();
        end else begin
            m_phase = '0;
            case (m_seq)
                BUS_START: begin
                    m_seq = BUS_BIT;
                    m_bit = '0;
                    enter_step();
                end
                BUS_BIT: begin
                    m_shift = m_shift << 1;
                    m_bit   = m_bit + 4'd1;
                    if (m_bit >= BITS_PER_BYTE) begin
                        m_seq = BUS_ACK;
                        m_bit = '0;
                    end
                    enter_step();
                end
                default: begin
                    m_seq   = BUS_IDLE;
                    m_ticks = '0;
                end
            endcase
        end
        return sampled;
    endfunction

    function automatic t_res predict_lines(t_cmd kind, logic [7:0] data, logic pin);
        t_res        r;
        logic        busy;
        logic        sampled;
        logic        rejected;
        int unsigned target;
        busy     = (m_seq != BUS_IDLE);
        sampled  = 1'b0;
        rejected = 1'b0;
        if (kind == CMD_TICK) begin
            if (busy) begin
                // a zero delay behaves as one tick
                target = (m_tpd == 8'd0) ? 1 : m_tpd;
                if (target > TICK_MAX) target = TICK_MAX;
                m_ticks = m_ticks + 1'b1;
                if (m_ticks >= target) sampled = end_delay_unit(pin);
            end
        end else if (busy) begin
            rejected = 1'b1;
        end else begin
            m_phase = '0;
            m_bit   = '0;
            case (kind)
                CMD_START: begin
                    m_shift = data;
                    m_seq   = BUS_START;
                end
                CMD_BYTE: begin
                    m_shift = data;
                    m_seq   = BUS_BIT;
                end
                default: m_seq = BUS_STOP;
            endcase
            enter_step();
        end
        r.scl       = m_scl;
        r.sda       = m_sda;
        r.busy      = (m_seq != BUS_IDLE);
        r.ack_valid = sampled;
        r.no_ack    = m_ack;
        r.rejected  = rejected;
        return r;
    endfunction

    task automatic report_mismatch(string what, int exp_v, int got_v);
        mismatch_cnt++;
        $display("mismatch on result %0d, %s: expected %0d, got %0d",
                 lines_seen, what, exp_v, got_v);
    endtask

    // monitor: predicts on each accepted request, checks each accepted result
    always @(posedge i_clk) begin
        t_res want;
        cycle_cnt <= cycle_cnt + 1;
        if (!i_rst_n) begin
            reset_line_model();
            line_exp_q.delete();
            req_taken <= 1'b0;
        end else begin
            if (i_cfg_we) m_tpd = i_cfg_wdata;
            req_taken <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                line_exp_q.push_back(predict_lines(t_cmd'(i_kind), i_data_byte, i_sda_in));
                cmds_taken++;
            end
            if (o_valid && !i_stall) begin
                if (line_exp_q.size() == 0) begin
                    report_mismatch("result with nothing expected", 0, 1);
                end else begin
                    want = line_exp_q.pop_front();
                    if (o_scl_out !== want.scl) report_mismatch("scl_out", want.scl, o_scl_out);
                    if (o_sda_out !== want.sda) report_mismatch("sda_out", want.sda, o_sda_out);
                    if (o_busy_res !== want.busy)
                        report_mismatch("busy_res", want.busy, o_busy_res);
                    if (o_ack_valid !== want.ack_valid)
                        report_mismatch("ack_valid", want.ack_valid, o_ack_valid);
                    if (o_no_ack !== want.no_ack) report_mismatch("no_ack", want.no_ack, o_no_ack);
                    if (o_cmd_rejected !== want.rejected)
                        report_mismatch("cmd_rejected", want.rejected, o_cmd_rejected);
                end
                lines_seen++;
            end
        end
    end

    // request driver: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        t_req item;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !req_taken) begin
            // hold the stalled request
        end else if (gap_left > 0) begin
            gap_left--;
            i_valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
            item = cmd_q.pop_front();
            i_kind      <= item.cmd;
            i_data_byte <= item.data;
            i_sda_in    <= item.sda;
            i_valid     <= 1'b1;
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // result receiver stall pattern, with one long hold-off to back up the queue
    t_rx_mode rx_mode   = RX_FREE;
    int       mode_left = 0;
    int       hold_left = 0;
    logic     hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!hold_done && cmd_q.size() > 40) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 60);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_FREE:     i_stall <= 1'b0;
                RX_COIN:     i_stall <= 1'($urandom_range(0, 1));
                RX_PERIODIC: i_stall <= (cycle_cnt % 3 == 0);
                default:     i_stall <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("[i2c_master_byte_writer] ERROR");
        $finish;
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_cmd(t_cmd kind, logic [7:0] data, logic pin);
        t_req item;
        item.cmd  = kind;
        item.data = data;
        item.sda  = pin;
        cmd_q.push_back(item);
        cmds_queued++;
    endtask

    // ticks carry a mostly low sda so that acks dominate
    task automatic add_ticks(int n);
        for (int k = 0; k < n; k++)
            add_cmd(CMD_TICK, pick_byte(), ($urandom_range(0, 3) == 0));
    endtask

    // extra ticks after a sequence, now and then too few so the next command collides
    function automatic int tick_slack(int unit);
        if ($urandom_range(0, 9) == 0) return -$urandom_range(1, 3 * unit);
        return $urandom_range(0, 2);
    endfunction

    task automatic add_write(int n_bytes, int unit);
        add_cmd(CMD_START, pick_byte(), 1'($urandom_range(0, 1)));
        add_ticks(30 * unit + tick_slack(unit));
        for (int b = 0; b < n_bytes; b++) begin
            add_cmd(CMD_BYTE, pick_byte(), 1'($urandom_range(0, 1)));
            add_ticks(27 * unit + tick_slack(unit));
        end
        add_cmd(CMD_STOP, pick_byte(), 1'($urandom_range(0, 1)));
        add_ticks(3 * unit + tick_slack(unit));
    endtask

    task automatic add_random_traffic(int budget, int unit);
        int first;
        int sel;
        first = cmds_queued;
        while (cmds_queued - first < budget) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                add_write($urandom_range(1, 2), unit);
            end else if (sel == 7) begin
                add_cmd(CMD_BYTE, pick_byte(), 1'($urandom_range(0, 1)));
                add_ticks(27 * unit + tick_slack(unit));
            end else begin
                repeat ($urandom_range(1, 6))
                    add_cmd(t_cmd'($urandom_range(0, 3)), pick_byte(),
                            1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic drain();
        while (cmds_taken != cmds_queued || line_exp_q.size() != 0) @(negedge i_clk);
    endtask

    // run ticks until the bus sequence is over, then let the pipeline empty
    task automatic settle_bus();
        drain();
        while (m_seq != BUS_IDLE) begin
            add_ticks(16);
            drain();
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_ticks_per_delay(logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int unit;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset delay of two ticks: idle tick, stop with no start, commands while busy
        add_cmd(CMD_TICK, 8'hFF, 1'b1);
        add_cmd(CMD_STOP, 8'h00, 1'b0);
        add_cmd(CMD_START, 8'hFF, 1'b1);
        add_cmd(CMD_BYTE, 8'h00, 1'b0);
        add_cmd(CMD_STOP, 8'hFF, 1'b1);
        add_ticks(6);
        add_cmd(CMD_TICK, 8'h00, 1'b0);
        add_cmd(CMD_BYTE, 8'hA5, 1'b1);
        add_cmd(CMD_TICK, 8'h5A, 1'b0);
        settle_bus();

        write_ticks_per_delay(8'd1);
        add_random_traffic(80, 1);
        settle_bus();

        // zero delay acts as one tick
        write_ticks_per_delay(8'd0);
        add_random_traffic(40, 1);
        settle_bus();

        // one full write with a longer delay unit
        unit = $urandom_range(2, 3);
        write_ticks_per_delay(unit[7:0]);
        add_write(1, unit);
        settle_bus();

        if (mismatch_cnt == 0) begin
            $display("[i2c_master_byte_writer] OK");
        end else begin
            $display("[i2c_master_byte_writer] ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/i2cmbw_pkg.sv
rtl/i2cmbw_front.sv
rtl/i2cmbw_back.sv
rtl/i2c_master_byte_writer.sv
dv/tb.sv
